@@ hdl/qau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types, codes and micro-op table of the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

   localparam int FRACTION_BITS_DEF = 16;
   localparam int COMP_W            = 32;
   localparam int MODE_W            = 3;
   localparam int STATUS_W          = 2;
   localparam int THR_W             = 31;
   localparam int REQ_TDATA_W       = 8 * COMP_W;
   localparam int RSP_TDATA_W       = 4 * COMP_W;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

   // operation modes
   localparam logic [MODE_W-1:0] MODE_MUL    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SCALE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ROT    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_UNROT  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_NORM   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_INV    = 3'd5;
   localparam logic [MODE_W-1:0] MODE_CONJ   = 3'd6;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

   // result status
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DEGEN = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

   // multiplier operand selects
   localparam logic [3:0] OP_A0  = 4'd0;
   localparam logic [3:0] OP_A1  = 4'd1;
   localparam logic [3:0] OP_A2  = 4'd2;
   localparam logic [3:0] OP_A3  = 4'd3;
   localparam logic [3:0] OP_B0  = 4'd4;
   localparam logic [3:0] OP_B1  = 4'd5;
   localparam logic [3:0] OP_B2  = 4'd6;
   localparam logic [3:0] OP_B3  = 4'd7;
   localparam logic [3:0] OP_C0  = 4'd8;
   localparam logic [3:0] OP_C1  = 4'd9;
   localparam logic [3:0] OP_C2  = 4'd10;
   localparam logic [3:0] OP_T0  = 4'd11;
   localparam logic [3:0] OP_T1  = 4'd12;
   localparam logic [3:0] OP_T2  = 4'd13;
   localparam logic [3:0] OP_ONE = 4'd14;
   localparam logic [3:0] OP_TWO = 4'd15;

   // accumulator destinations
   localparam logic [3:0] DST_R0 = 4'd0;
   localparam logic [3:0] DST_R1 = 4'd1;
   localparam logic [3:0] DST_R2 = 4'd2;
   localparam logic [3:0] DST_R3 = 4'd3;
   localparam logic [3:0] DST_C0 = 4'd4;
   localparam logic [3:0] DST_C1 = 4'd5;
   localparam logic [3:0] DST_C2 = 4'd6;
   localparam logic [3:0] DST_T0 = 4'd7;
   localparam logic [3:0] DST_T1 = 4'd8;
   localparam logic [3:0] DST_T2 = 4'd9;
   localparam logic [3:0] DST_S  = 4'd10;

   typedef struct packed {
      logic [3:0] xsel;
      logic [3:0] ysel;
      logic       neg;   // subtract the product
      logic [3:0] dst;
      logic       last;  // last term of a sum
      logic       fin;   // last term of the sequence
   } uop_type;

   function automatic uop_type uop_make(input logic [3:0] xs, input logic [3:0] ys,
                                        input logic ng, input logic [3:0] ds,
                                        input logic lst, input logic fn);
      uop_type u;
      u.xsel = xs;
      u.ysel = ys;
      u.neg  = ng;
      u.dst  = ds;
      u.last = lst;
      u.fin  = fn;
      return u;
   endfunction

   function automatic uop_type uop_lookup(input logic [MODE_W-1:0] mode,
                                          input logic [4:0] step);
      uop_type    u;
      logic       f;
      logic [3:0] i4;
      f  = (mode == MODE_UNROT);
      i4 = 4'(step[1:0]);
      u  = uop_make(OP_A0, OP_A0, 1'b0, DST_R0, 1'b1, 1'b1);
      case (mode)
         MODE_MUL: begin
            case (step)
               5'd0:  u = uop_make(OP_A3, OP_B0, 1'b0, DST_R0, 1'b0, 1'b0);
               5'd1:  u = uop_make(OP_A0, OP_B3, 1'b0, DST_R0, 1'b0, 1'b0);
               5'd2:  u = uop_make(OP_A1, OP_B2, 1'b0, DST_R0, 1'b0, 1'b0);
               5'd3:  u = uop_make(OP_A2, OP_B1, 1'b1, DST_R0, 1'b1, 1'b0);
               5'd4:  u = uop_make(OP_A3, OP_B1, 1'b0, DST_R1, 1'b0, 1'b0);
               5'd5:  u = uop_make(OP_A0, OP_B2, 1'b1, DST_R1, 1'b0, 1'b0);
               5'd6:  u = uop_make(OP_A1, OP_B3, 1'b0, DST_R1, 1'b0, 1'b0);
               5'd7:  u = uop_make(OP_A2, OP_B0, 1'b0, DST_R1, 1'b1, 1'b0);
               5'd8:  u = uop_make(OP_A3, OP_B2, 1'b0, DST_R2, 1'b0, 1'b0);
               5'd9:  u = uop_make(OP_A0, OP_B1, 1'b0, DST_R2, 1'b0, 1'b0);
               5'd10: u = uop_make(OP_A1, OP_B0, 1'b1, DST_R2, 1'b0, 1'b0);
               5'd11: u = uop_make(OP_A2, OP_B3, 1'b0, DST_R2, 1'b1, 1'b0);
               5'd12: u = uop_make(OP_A3, OP_B3, 1'b0, DST_R3, 1'b0, 1'b0);
               5'd13: u = uop_make(OP_A0, OP_B0, 1'b1, DST_R3, 1'b0, 1'b0);
               5'd14: u = uop_make(OP_A1, OP_B1, 1'b1, DST_R3, 1'b0, 1'b0);
               5'd15: u = uop_make(OP_A2, OP_B2, 1'b1, DST_R3, 1'b1, 1'b1);
               default: u = uop_make(OP_A0, OP_A0, 1'b0, DST_R0, 1'b1, 1'b1);
            endcase
         end
         MODE_SCALE: u = uop_make(OP_A0 + i4, OP_B3, 1'b0, DST_R0 + i4, 1'b1,
                                  step[1:0] == 2'd3);
         MODE_ROT, MODE_UNROT: begin
            // c = axis x v, t = w*c + axis x c, r = v + 2t
            case (step)
               5'd0:  u = uop_make(OP_A1, OP_B2, f,  DST_C0, 1'b0, 1'b0);
               5'd1:  u = uop_make(OP_A2, OP_B1, !f, DST_C0, 1'b1, 1'b0);
               5'd2:  u = uop_make(OP_A2, OP_B0, f,  DST_C1, 1'b0, 1'b0);
               5'd3:  u = uop_make(OP_A0, OP_B2, !f, DST_C1, 1'b1, 1'b0);
               5'd4:  u = uop_make(OP_A0, OP_B1, f,  DST_C2, 1'b0, 1'b0);
               5'd5:  u = uop_make(OP_A1, OP_B0, !f, DST_C2, 1'b1, 1'b0);
               5'd6:  u = uop_make(OP_A3, OP_C0, 1'b0, DST_T0, 1'b0, 1'b0);
               5'd7:  u = uop_make(OP_A1, OP_C2, f,    DST_T0, 1'b0, 1'b0);
               5'd8:  u = uop_make(OP_A2, OP_C1, !f,   DST_T0, 1'b1, 1'b0);
               5'd9:  u = uop_make(OP_A3, OP_C1, 1'b0, DST_T1, 1'b0, 1'b0);
               5'd10: u = uop_make(OP_A2, OP_C0, f,    DST_T1, 1'b0, 1'b0);
               5'd11: u = uop_make(OP_A0, OP_C2, !f,   DST_T1, 1'b1, 1'b0);
               5'd12: u = uop_make(OP_A3, OP_C2, 1'b0, DST_T2, 1'b0, 1'b0);
               5'd13: u = uop_make(OP_A0, OP_C1, f,    DST_T2, 1'b0, 1'b0);
               5'd14: u = uop_make(OP_A1, OP_C0, !f,   DST_T2, 1'b1, 1'b0);
               5'd15: u = uop_make(OP_B0, OP_ONE, 1'b0, DST_R0, 1'b0, 1'b0);
               5'd16: u = uop_make(OP_T0, OP_TWO, 1'b0, DST_R0, 1'b1, 1'b0);
               5'd17: u = uop_make(OP_B1, OP_ONE, 1'b0, DST_R1, 1'b0, 1'b0);
               5'd18: u = uop_make(OP_T1, OP_TWO, 1'b0, DST_R1, 1'b1, 1'b0);
               5'd19: u = uop_make(OP_B2, OP_ONE, 1'b0, DST_R2, 1'b0, 1'b0);
               5'd20: u = uop_make(OP_T2, OP_TWO, 1'b0, DST_R2, 1'b1, 1'b1);
               default: u = uop_make(OP_A0, OP_A0, 1'b0, DST_R0, 1'b1, 1'b1);
            endcase
         end
         MODE_NORM, MODE_INV: u = uop_make(OP_A0 + i4, OP_A0 + i4, 1'b0, DST_S,
                                           step[1:0] == 2'd3, step[1:0] == 2'd3);
         MODE_CONJ: u = uop_make(OP_A0 + i4, OP_ONE, step[1:0] != 2'd3, DST_R0 + i4,
                                 1'b1, step[1:0] == 2'd3);
         default: u = uop_make(OP_A0, OP_A0, 1'b0, DST_R0, 1'b1, 1'b1);
      endcase
      return u;
   endfunction

endpackage

@@ hdl/quaternion_arithmetic_unit_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_core
// Fixed-point quaternion unit: product, scale, rotate, unrotate, conjugate, normalize, inverse.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation per transaction (mode in req_tuser, A and B in
//   req_tdata); rsp_* returns one result per transaction (status in tuser).
//   csr_* writes the degenerate-norm threshold; write it only while idle.
//   A single 32x32 multiplier and accumulator walk through a micro-op table;
//   each product term is registered in a multiply state, then accumulated.
//   An unknown mode skips the table and returns a zero result.
//   After the norm sum, normalize runs a digit-serial square root (33 steps)
//   and normalize and inverse run a restoring divider (33 steps per component).
//   One item is in flight at a time: req_tready is high only when idle.
//   The result sits in an output register; a stalled receiver does not stop
//   the next item from being accepted, only its final hand-off.
//   Synchronous reset clears the sequencer and output valid and sets the
//   threshold to 1.0 LSB.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_core
   import qau_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (32 bits each)
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // mode
   input  logic [MODE_W-1:0]      req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // r_x, r_y, r_z, r_w (32 bits each)
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // status
   output logic [STATUS_W-1:0]    rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [THR_W-1:0]       csr_data
);

   localparam int ACC_W   = 66;
   localparam int SUM_W   = 65;
   localparam int SQ_W    = 66;
   localparam int DIV_D_W = 65;
   localparam int REM_W   = 66;
   localparam int QW      = 33;
   localparam int NUM_W   = COMP_W + 2 * FRACTION_BITS;
   localparam int CNT_W   = 6;
   localparam int SH_W    = 6;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL   = 4'd1;
   localparam logic [3:0] ST_ACC   = 4'd2;
   localparam logic [3:0] ST_CHK   = 4'd3;
   localparam logic [3:0] ST_NORM  = 4'd4;
   localparam logic [3:0] ST_SQRT  = 4'd5;
   localparam logic [3:0] ST_DLOAD = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_DWR   = 4'd8;
   localparam logic [3:0] ST_FIN   = 4'd9;

   localparam logic signed [COMP_W-1:0] ONE_Q = 32'sd1 <<< FRACTION_BITS;
   localparam logic signed [COMP_W-1:0] TWO_Q = 32'sd2 <<< FRACTION_BITS;
   localparam logic signed [ACC_W-1:0]  SAT_HI = ACC_W'(2147483647);
   localparam logic signed [ACC_W-1:0]  SAT_LO = -SAT_HI - ACC_W'(1);
   localparam logic [SQ_W-1:0]          NORM_LIM = SQ_W'(1) << 62;
   localparam logic [SQ_W-1:0]          SQ_TOP   = SQ_W'(1) << 64;

   // {saturated, value}
   function automatic logic [COMP_W:0] sat_to32(input logic signed [ACC_W-1:0] v);
      logic [COMP_W:0] o;
      if (v > SAT_HI) begin
         o = {1'b1, SAT_HI[COMP_W-1:0]};
      end else if (v < SAT_LO) begin
         o = {1'b1, SAT_LO[COMP_W-1:0]};
      end else begin
         o = {1'b0, v[COMP_W-1:0]};
      end
      return o;
   endfunction

   logic [3:0]               state_ff, state_in;
   logic [MODE_W-1:0]        mode_ff, mode_in;
   logic signed [COMP_W-1:0] a_ff [4];
   logic signed [COMP_W-1:0] a_in [4];
   logic signed [COMP_W-1:0] b_ff [4];
   logic signed [COMP_W-1:0] b_in [4];
   logic signed [COMP_W-1:0] tmp_ff [6];
   logic signed [COMP_W-1:0] tmp_in [6];
   logic signed [COMP_W-1:0] r_ff [4];
   logic signed [COMP_W-1:0] r_in [4];
   logic                     sat_ff, sat_in;
   logic                     degen_ff, degen_in;
   logic [4:0]               step_ff, step_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [SUM_W-1:0]         s_ff, s_in;
   logic [SQ_W-1:0]          sn_ff, sn_in;
   logic [SQ_W-1:0]          res_ff, res_in;
   logic [SQ_W-1:0]          bit_ff, bit_in;
   logic [4:0]               k_ff, k_in;
   logic [DIV_D_W-1:0]       dd_ff, dd_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [QW-1:0]            nlo_ff, nlo_in;
   logic [QW-1:0]            q_ff, q_in;
   logic                     ovf_ff, ovf_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [1:0]               comp_ff, comp_in;
   logic [THR_W-1:0]         thr_ff, thr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]      rsp_user_ff, rsp_user_in;

   uop_type                  uop;
   logic signed [COMP_W-1:0] opnd [16];
   logic signed [63:0]       x_ext, y_ext;
   logic signed [ACC_W-1:0]  term, acc_sum, acc_shr;
   logic [COMP_W:0]          acc_sat;
   logic [SQ_W-1:0]          sq_try;
   logic signed [COMP_W-1:0] a_sel;
   logic [COMP_W-1:0]        mag;
   logic [SH_W-1:0]          sh;
   logic [NUM_W-1:0]         num, num_hi;
   logic [REM_W-1:0]         rem_sh;
   logic                     q_neg;
   logic signed [QW:0]       q_signed;
   logic [COMP_W:0]          q_sat;
   logic                     out_free;

   assign uop = uop_lookup(mode_ff, step_ff);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         opnd[i]     = a_ff[i];
         opnd[4 + i] = b_ff[i];
      end
      for (int i = 0; i < 6; i++) begin
         opnd[8 + i] = tmp_ff[i];
      end
      opnd[14] = ONE_Q;
      opnd[15] = TWO_Q;
   end

   assign x_ext   = 64'(opnd[uop.xsel]);
   assign y_ext   = 64'(opnd[uop.ysel]);
   assign prod_in = x_ext * y_ext;

   // sum of products, floor-shifted back to Q format
   assign term    = uop.neg ? -ACC_W'(prod_ff) : ACC_W'(prod_ff);
   assign acc_sum = acc_ff + term;
   assign acc_shr = acc_sum >>> FRACTION_BITS;
   assign acc_sat = sat_to32(acc_shr);

   assign sq_try = res_ff + bit_ff;

   assign a_sel  = a_ff[comp_ff];
   assign mag    = a_sel[COMP_W-1] ? (~a_sel + COMP_W'(1)) : a_sel;
   assign sh     = (mode_ff == MODE_NORM) ? (SH_W'(k_ff) + SH_W'(FRACTION_BITS))
                                          : SH_W'(2 * FRACTION_BITS);
   assign num    = NUM_W'(mag) << sh;
   assign num_hi = num >> QW;
   assign rem_sh = {rem_ff[REM_W-2:0], nlo_ff[QW-1]};

   // inverse flips the vector part
   assign q_neg    = a_sel[COMP_W-1] ^ ((mode_ff == MODE_INV) && (comp_ff != 2'd3));
   assign q_signed = q_neg ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
   assign q_sat    = ovf_ff ? {1'b1, (q_neg ? SAT_LO[COMP_W-1:0] : SAT_HI[COMP_W-1:0])}
                            : sat_to32(ACC_W'(q_signed));

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      tmp_in       = tmp_ff;
      r_in         = r_ff;
      sat_in       = sat_ff;
      degen_in     = degen_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      s_in         = s_ff;
      sn_in        = sn_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      k_in         = k_ff;
      dd_in        = dd_ff;
      rem_in       = rem_ff;
      nlo_in       = nlo_ff;
      q_in         = q_ff;
      ovf_in       = ovf_ff;
      cnt_in       = cnt_ff;
      comp_in      = comp_ff;
      thr_in       = thr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (csr_valid) begin
         thr_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in = req_tuser;
               for (int i = 0; i < 4; i++) begin
                  a_in[i] = req_tdata[COMP_W*i +: COMP_W];
                  b_in[i] = req_tdata[COMP_W*(4+i) +: COMP_W];
                  r_in[i] = '0;
               end
               sat_in   = 1'b0;
               degen_in = 1'b0;
               step_in  = '0;
               acc_in   = '0;
               state_in = (req_tuser == MODE_UNUSED) ? ST_FIN : ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (uop.last) begin
               acc_in = '0;
               if (uop.dst == DST_S) begin
                  s_in = acc_sum[SUM_W-1:0];
               end else begin
                  sat_in = sat_ff | acc_sat[COMP_W];
                  if (uop.dst < DST_C0) begin
                     r_in[uop.dst[1:0]] = acc_sat[COMP_W-1:0];
                  end else begin
                     tmp_in[3'(uop.dst - DST_C0)] = acc_sat[COMP_W-1:0];
                  end
               end
            end else begin
               acc_in = acc_sum;
            end
            if (uop.fin) begin
               state_in = (uop.dst == DST_S) ? ST_CHK : ST_FIN;
            end else begin
               step_in  = step_ff + 5'd1;
               state_in = ST_MUL;
            end
         end
         ST_CHK: begin
            comp_in = '0;
            if ((s_ff >> FRACTION_BITS) <= SUM_W'(thr_ff)) begin
               degen_in = 1'b1;
               r_in[3]  = ONE_Q;
               state_in = ST_FIN;
            end else if (mode_ff == MODE_NORM) begin
               sn_in    = SQ_W'(s_ff);
               k_in     = '0;
               state_in = ST_NORM;
            end else begin
               dd_in    = s_ff;
               state_in = ST_DLOAD;
            end
         end
         ST_NORM: begin
            // bring the sum up to at least 2^62, two bits a step
            if (sn_ff < NORM_LIM) begin
               sn_in = sn_ff << 2;
               k_in  = k_ff + 5'd1;
            end else begin
               res_in   = '0;
               bit_in   = SQ_TOP;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sn_ff >= sq_try) begin
               sn_in  = sn_ff - sq_try;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == SQ_W'(1)) begin
               dd_in    = res_in[DIV_D_W-1:0];
               state_in = ST_DLOAD;
            end
         end
         ST_DLOAD: begin
            ovf_in   = REM_W'(num_hi) >= REM_W'(dd_ff);
            rem_in   = REM_W'(num_hi);
            nlo_in   = num[QW-1:0];
            q_in     = '0;
            cnt_in   = CNT_W'(QW - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_sh >= REM_W'(dd_ff)) begin
               rem_in = rem_sh - REM_W'(dd_ff);
               q_in   = {q_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               q_in   = {q_ff[QW-2:0], 1'b0};
            end
            nlo_in = nlo_ff << 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DWR;
            end
         end
         ST_DWR: begin
            r_in[comp_ff] = q_sat[COMP_W-1:0];
            sat_in        = sat_ff | q_sat[COMP_W];
            if (comp_ff == 2'd3) begin
               state_in = ST_FIN;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = ST_DLOAD;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {r_ff[3], r_ff[2], r_ff[1], r_ff[0]};
               rsp_user_in  = degen_ff ? STATUS_DEGEN : (sat_ff ? STATUS_SAT : STATUS_OK);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THR_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      tmp_ff      <= tmp_in;
      r_ff        <= r_in;
      sat_ff      <= sat_in;
      degen_ff    <= degen_in;
      step_ff     <= step_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      s_ff        <= s_in;
      sn_ff       <= sn_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      k_ff        <= k_in;
      dd_ff       <= dd_in;
      rem_ff      <= rem_in;
      nlo_ff      <= nlo_in;
      q_ff        <= q_in;
      ovf_ff      <= ovf_in;
      cnt_ff      <= cnt_in;
      comp_ff     <= comp_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign csr_ready  = 1'b1;

endmodule

@@ hdl/qau_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_checker
// Port-level checks for the quaternion arithmetic unit, bound to the core.
// ----------------------------------------------------------------------------
module qau_checker
   import qau_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]    rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   // one transaction in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted while busy");

   // degenerate norm gives a zero vector part
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_DEGEN) |-> rsp_tdata[3*COMP_W-1:0] == '0)
      else $error("degenerate result not identity");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

endmodule

bind quaternion_arithmetic_unit_core qau_checker u_qau_checker (.*);
